// File: rtl/core/hash_pair_hamming_histogram_defines.svh
// ----------------------------------------------------------------------------
// Hash pair Hamming histogram assertion macros
// Shorthand for the concurrent checks in the datapath module.
// ----------------------------------------------------------------------------
`ifndef HASH_PAIR_HAMMING_HISTOGRAM_DEFINES_SVH
`define HASH_PAIR_HAMMING_HISTOGRAM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPHH_ASSERT_NOW(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HPHH_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// File: rtl/core/hphh_pkg.sv
// ----------------------------------------------------------------------------
// Hash pair Hamming histogram package
// Types, codes and the bit count function shared by the core modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hphh_pkg;

	localparam int HASH_W   = 64;
	localparam int IDX_W    = 6;
	localparam int IDX_LIMIT = 64;
	localparam int BIN_W    = 7;
	localparam int NUM_BINS = 65;
	localparam int TALLY_W  = 11;
	localparam logic [TALLY_W-1:0] TALLY_MAX = 11'h7FF;

	typedef enum logic [0:0] {
		ACT_INSERT = 1'b0,
		ACT_READ   = 1'b1
	} hphh_action_t;

	typedef enum logic [1:0] {
		KIND_PAIR = 2'd0,
		KIND_DONE = 2'd1,
		KIND_BIN  = 2'd2,
		KIND_FULL = 2'd3
	} hphh_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_ISSUE,
		ST_RD_SHOW,
		ST_FULL_SHOW,
		ST_CMP,
		ST_DRAIN,
		ST_DONE_SHOW
	} hphh_state_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic show_bin;
		logic show_full;
		logic show_done;
	} hphh_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic cmp_last;
		logic pipe_busy;
	} hphh_stat_t;

	// Adder tree over the 64 bits, six levels of independent sums.
	function automatic logic [BIN_W-1:0] popcount64(input logic [HASH_W-1:0] x);
		logic [1:0] l1 [32];
		logic [2:0] l2 [16];
		logic [3:0] l3 [8];
		logic [4:0] l4 [4];
		logic [5:0] l5 [2];
		int i;
		for (i = 0; i < 32; i++) begin
			l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
		end
		for (i = 0; i < 16; i++) begin
			l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		end
		for (i = 0; i < 8; i++) begin
			l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		end
		for (i = 0; i < 4; i++) begin
			l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		end
		for (i = 0; i < 2; i++) begin
			l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
		end
		return {1'b0, l5[0]} + {1'b0, l5[1]};
	endfunction

endpackage

// File: rtl/core/hphh_ctrl.sv
// ----------------------------------------------------------------------------
// Hash pair Hamming histogram controller
// Sequences bin reads, store-full errors and insert compare runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hphh_ctrl
	import hphh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       action,
	output logic       busy,
	input  hphh_stat_t stat,
	output hphh_cmd_t  cmd
);

	hphh_state_t state_q;
	hphh_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (action == ACT_READ) begin
						state_next = ST_RD_ISSUE;
					end else if (stat.full) begin
						state_next = ST_FULL_SHOW;
					end else if (stat.empty) begin
						state_next = ST_DRAIN;
					end else begin
						state_next = ST_CMP;
					end
				end
			end
			ST_RD_ISSUE:  state_next = ST_RD_SHOW;
			ST_RD_SHOW:   state_next = ST_IDLE;
			ST_FULL_SHOW: state_next = ST_IDLE;
			ST_CMP: begin
				if (stat.cmp_last) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// The last histogram write must land before the done result.
				if (!stat.pipe_busy) begin
					state_next = ST_DONE_SHOW;
				end
			end
			ST_DONE_SHOW: state_next = ST_IDLE;
			default:      state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_CMP:       cmd.issue     = 1'b1;
			ST_RD_SHOW:   cmd.show_bin  = 1'b1;
			ST_FULL_SHOW: cmd.show_full = 1'b1;
			ST_DONE_SHOW: cmd.show_done = 1'b1;
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/core/hphh_dpath.sv
// ----------------------------------------------------------------------------
// Hash pair Hamming histogram datapath
// Hash store, compare pipeline, histogram memory and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hash_pair_hamming_histogram_defines.svh"

module hphh_dpath
	import hphh_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hphh_cmd_t           cmd,
	output hphh_stat_t          stat,
	input  logic [HASH_W-1:0]   hash_value,
	input  logic [BIN_W-1:0]    bin_select,
	input  logic                cfg_we,
	input  logic [BIN_W-1:0]    cfg_data,
	output logic                strobe,
	output logic [1:0]          kind,
	output logic [IDX_W-1:0]    older_index,
	output logic [IDX_W-1:0]    newer_index,
	output logic [BIN_W-1:0]    distance,
	output logic [TALLY_W-1:0]  tally,
	output logic                last
);

	localparam int STORE_LIMIT = (CAPACITY < IDX_LIMIT) ? CAPACITY : IDX_LIMIT;
	localparam int SAW = $clog2(STORE_LIMIT);
	localparam int CW  = $clog2(STORE_LIMIT + 1);

	// Control registers.
	logic [BIN_W-1:0] max_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    match_q;
	logic             v1_q, v2_q, v3_q;
	logic             hit_s3;
	logic             wr_v_q;
	logic             strobe_q;
	logic             hist_vld [NUM_BINS];

	// Payload registers.
	logic [HASH_W-1:0]  hash_q;
	logic [BIN_W-1:0]   bin_q;
	logic [HASH_W-1:0]  store_rd_s1;
	logic [SAW-1:0]     addr_s1, addr_s2;
	logic [BIN_W-1:0]   dist_s2, dist_s3;
	logic [TALLY_W-1:0] hist_rd_s3;
	logic [BIN_W-1:0]   wr_addr_q;
	logic [TALLY_W-1:0] wr_data_q;
	hphh_kind_t         kind_q;
	logic [IDX_W-1:0]   older_q, newer_q;
	logic [BIN_W-1:0]   dist_q;
	logic [TALLY_W-1:0] tally_q;
	logic               last_q;

	logic [HASH_W-1:0]  store_mem [STORE_LIMIT];
	logic [TALLY_W-1:0] hist_mem [NUM_BINS];

	logic [BIN_W-1:0]   hist_addr;
	logic               hist_hit;
	logic [TALLY_W-1:0] hist_cur;
	logic [TALLY_W-1:0] hist_new;
	logic               pair_hit;

	assign stat.full      = (count_q == CW'(STORE_LIMIT));
	assign stat.empty     = (count_q == '0);
	assign stat.cmp_last  = ((idx_q + CW'(1)) == count_q);
	assign stat.pipe_busy = v1_q | v2_q | v3_q;

	// During a run the read port follows the compare stage, otherwise the
	// requested bin.
	assign hist_addr = v2_q ? dist_s2 : bin_q;
	assign hist_hit  = (hist_addr < BIN_W'(NUM_BINS)) && hist_vld[hist_addr];

	// A write in the previous cycle is not yet seen by this cycle's read data.
	assign hist_cur = (wr_v_q && (wr_addr_q == dist_s3)) ? wr_data_q :
		(hit_s3 ? hist_rd_s3 : '0);
	assign hist_new = (hist_cur == TALLY_MAX) ? hist_cur : hist_cur + TALLY_W'(1);

	assign pair_hit = v2_q && (dist_s2 <= max_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			match_q  <= '0;
			v1_q     <= 1'b0;
			v2_q     <= 1'b0;
			v3_q     <= 1'b0;
			hit_s3   <= 1'b0;
			wr_v_q   <= 1'b0;
			strobe_q <= 1'b0;
			for (int b = 0; b < NUM_BINS; b++) begin
				hist_vld[b] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				max_q <= cfg_data;
			end
			if (cmd.accept) begin
				idx_q   <= '0;
				match_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (pair_hit) begin
				match_q <= match_q + CW'(1);
			end
			if (cmd.show_done) begin
				count_q <= count_q + CW'(1);
			end
			v1_q   <= cmd.issue;
			v2_q   <= v1_q;
			v3_q   <= v2_q;
			hit_s3 <= hist_hit;
			wr_v_q <= v3_q;
			if (v3_q) begin
				hist_vld[dist_s3] <= 1'b1;
			end
			strobe_q <= pair_hit | cmd.show_bin | cmd.show_full | cmd.show_done;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			hash_q <= hash_value;
			bin_q  <= bin_select;
		end
		addr_s1   <= idx_q[SAW-1:0];
		addr_s2   <= addr_s1;
		dist_s2   <= popcount64(store_rd_s1 ^ hash_q);
		dist_s3   <= dist_s2;
		wr_addr_q <= dist_s3;
		wr_data_q <= hist_new;
	end

	// Hash store: one read port for the compare run, one write at run end.
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			store_rd_s1 <= store_mem[idx_q[SAW-1:0]];
		end
		if (cmd.show_done) begin
			store_mem[count_q[SAW-1:0]] <= hash_q;
		end
	end

	// Histogram: read-modify-write, one bin per cycle.
	always_ff @(posedge clk) begin
		if (hist_hit) begin
			hist_rd_s3 <= hist_mem[hist_addr];
		end
		if (v3_q) begin
			hist_mem[dist_s3] <= hist_new;
		end
	end

	always_ff @(posedge clk) begin
		if (pair_hit) begin
			kind_q  <= KIND_PAIR;
			older_q <= IDX_W'(addr_s2);
			newer_q <= IDX_W'(count_q);
			dist_q  <= dist_s2;
			tally_q <= '0;
			last_q  <= 1'b0;
		end else if (cmd.show_done) begin
			kind_q  <= KIND_DONE;
			older_q <= '0;
			newer_q <= IDX_W'(count_q);
			dist_q  <= '0;
			tally_q <= TALLY_W'(match_q);
			last_q  <= 1'b1;
		end else if (cmd.show_bin) begin
			kind_q  <= KIND_BIN;
			older_q <= '0;
			newer_q <= '0;
			dist_q  <= '0;
			tally_q <= hit_s3 ? hist_rd_s3 : '0;
			last_q  <= 1'b1;
		end else if (cmd.show_full) begin
			kind_q  <= KIND_FULL;
			older_q <= '0;
			newer_q <= '0;
			dist_q  <= '0;
			tally_q <= '0;
			last_q  <= 1'b1;
		end
	end

	assign strobe      = strobe_q;
	assign kind        = kind_q;
	assign older_index = older_q;
	assign newer_index = newer_q;
	assign distance    = dist_q;
	assign tally       = tally_q;
	assign last        = last_q;

	`HPHH_ASSERT_NOW(a_issue_in_range, cmd.issue, idx_q < count_q, "compare reads an unwritten entry")
	`HPHH_ASSERT_NOW(a_done_drained, cmd.show_done, !(v1_q || v2_q || v3_q || wr_v_q), "done result before histogram updates finished")
	`HPHH_ASSERT_NOW(a_bin_in_range, v3_q, dist_s3 <= BIN_W'(NUM_BINS - 1), "distance beyond last histogram bin")
	`HPHH_ASSERT_NEXT(a_count_step, cmd.show_done, count_q == $past(count_q) + CW'(1), "entry count did not advance by one")

endmodule

// File: rtl/core/hash_pair_hamming_histogram.sv
// ----------------------------------------------------------------------------
// Hash pair Hamming histogram
// Stores 64-bit hashes, reports close pairs and keeps a distance histogram.
// ----------------------------------------------------------------------------
//
// Channel   Ports                                           Direction
// request   start, busy, action, hash_value, bin_select     in (busy out)
// result    strobe, kind, older_index, newer_index,
//           distance, tally, last                           out
// config    cfg_we, cfg_data (distance limit)               in
//
// An insert into a non-empty store keeps busy high while it reads the
// store one entry per cycle, drains the last compare's pipeline and
// histogram write and shows the done result. An empty-store insert drains
// and shows done, a bin read issues and shows, a store-full insert only
// shows. Each result is registered onto strobe for one cycle; no stalls.
// Reset clears the entry count, the distance limit and the histogram.
`timescale 1ns / 1ps

module hash_pair_hamming_histogram
	import hphh_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                action,
	input  logic [HASH_W-1:0]   hash_value,
	input  logic [BIN_W-1:0]    bin_select,
	input  logic                cfg_we,
	input  logic [BIN_W-1:0]    cfg_data,
	output logic                strobe,
	output logic [1:0]          kind,
	output logic [IDX_W-1:0]    older_index,
	output logic [IDX_W-1:0]    newer_index,
	output logic [BIN_W-1:0]    distance,
	output logic [TALLY_W-1:0]  tally,
	output logic                last
);

	hphh_cmd_t  cmd;
	hphh_stat_t stat;

	hphh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	hphh_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.hash_value  (hash_value),
		.bin_select  (bin_select),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.strobe      (strobe),
		.kind        (kind),
		.older_index (older_index),
		.newer_index (newer_index),
		.distance    (distance),
		.tally       (tally),
		.last        (last)
	);

endmodule

// File: test/hash_pair_hamming_histogram_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash pair Hamming histogram checker
// Watches the request, result and configuration ports, predicts the result
// sequence of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------

module hash_pair_hamming_histogram_checker
	import hphh_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic                action,
	input  logic [HASH_W-1:0]   hash_value,
	input  logic [BIN_W-1:0]    bin_select,
	input  logic                cfg_we,
	input  logic [BIN_W-1:0]    cfg_data,
	input  logic                strobe,
	input  logic [1:0]          kind,
	input  logic [IDX_W-1:0]    older_index,
	input  logic [IDX_W-1:0]    newer_index,
	input  logic [BIN_W-1:0]    distance,
	input  logic [TALLY_W-1:0]  tally,
	input  logic                last,
	output int                  fail_count,
	output int                  pending
);

	localparam int STORE_LIMIT = (CAPACITY < IDX_LIMIT) ? CAPACITY : IDX_LIMIT;

	typedef struct packed {
		hphh_kind_t          kind;
		logic [IDX_W-1:0]    older;
		logic [IDX_W-1:0]    newer;
		logic [BIN_W-1:0]    dist_val;
		logic [TALLY_W-1:0]  tally;
		logic                last;
	} report_t;

	logic [HASH_W-1:0]   stored_hash [IDX_LIMIT];
	logic [TALLY_W-1:0]  bin_count [NUM_BINS];
	int                  entry_total = 0;
	logic [BIN_W-1:0]    dist_limit = '0;
	report_t             awaited_reports [$];

	task automatic predict_hash_request(input logic act, input logic [HASH_W-1:0] hv,
			input logic [BIN_W-1:0] bin);
		report_t rep;
		int d;
		int match_total;
		int slot;
		rep = '0;
		rep.last = 1'b1;
		if (act == ACT_READ) begin
			rep.kind = KIND_BIN;
			rep.tally = (bin < NUM_BINS) ? bin_count[bin] : '0;
			awaited_reports = {awaited_reports, rep};
		end else if (entry_total >= STORE_LIMIT) begin
			// Nothing is stored or counted once the store is full.
			rep.kind = KIND_FULL;
			awaited_reports = {awaited_reports, rep};
		end else begin
			match_total = 0;
			for (slot = 0; slot < entry_total; slot++) begin
				d = $countones(stored_hash[slot] ^ hv);
				if (bin_count[d] < TALLY_MAX) begin
					bin_count[d] = bin_count[d] + 1'b1;
				end
				if (d <= dist_limit) begin
					rep = '0;
					rep.kind = KIND_PAIR;
					rep.older = IDX_W'(slot);
					rep.newer = IDX_W'(entry_total);
					rep.dist_val = BIN_W'(d);
					awaited_reports = {awaited_reports, rep};
					match_total++;
				end
			end
			stored_hash[entry_total] = hv;
			rep = '0;
			rep.kind = KIND_DONE;
			rep.newer = IDX_W'(entry_total);
			rep.tally = TALLY_W'(match_total);
			rep.last = 1'b1;
			awaited_reports = {awaited_reports, rep};
			entry_total++;
		end
	endtask

	task automatic check_report();
		report_t want;
		bit bad;
		if (awaited_reports.size() == 0) begin
			$display("%0t unexpected result: kind %0d older %0d newer %0d",
				$time, kind, older_index, newer_index);
			$display("%0t   distance %0d tally %0d last %0d", $time, distance, tally,
				last);
			fail_count++;
		end else begin
			want = awaited_reports.pop_front();
			bad = 1'b0;
			if (kind !== want.kind) begin
				$display("%0t kind: expected %0d, actual %0d", $time, want.kind, kind);
				bad = 1'b1;
			end
			if (older_index !== want.older) begin
				$display("%0t older_index: expected %0d, actual %0d", $time, want.older,
					older_index);
				bad = 1'b1;
			end
			if (newer_index !== want.newer) begin
				$display("%0t newer_index: expected %0d, actual %0d", $time, want.newer,
					newer_index);
				bad = 1'b1;
			end
			if (distance !== want.dist_val) begin
				$display("%0t distance: expected %0d, actual %0d", $time, want.dist_val,
					distance);
				bad = 1'b1;
			end
			if (tally !== want.tally) begin
				$display("%0t tally: expected %0d, actual %0d", $time, want.tally, tally);
				bad = 1'b1;
			end
			if (last !== want.last) begin
				$display("%0t last: expected %0d, actual %0d", $time, want.last, last);
				bad = 1'b1;
			end
			if (bad) begin
				fail_count++;
			end
		end
	endtask

	// Results of a request accepted at this edge cannot appear before the next one,
	// so checking ahead of predicting is safe.
	always @(posedge clk) begin
		if (!arst_n) begin
			fail_count = 0;
			pending = 0;
			entry_total = 0;
			dist_limit = '0;
			awaited_reports.delete();
			for (int b = 0; b < NUM_BINS; b++) begin
				bin_count[b] = '0;
			end
		end else begin
			if (strobe === 1'b1) begin
				check_report();
			end
			if (cfg_we) begin
				dist_limit = cfg_data;
			end
			if (start && !busy) begin
				predict_hash_request(action, hash_value, bin_select);
			end
			pending = awaited_reports.size();
		end
	end

endmodule

// File: test/tb_hash_pair_hamming_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash pair Hamming histogram testbench
// Drives directed and random insert and bin read requests in bursts under
// several distance limits, fills the store past capacity, and leaves
// prediction and comparison to the checker.
// ----------------------------------------------------------------------------

module tb_hash_pair_hamming_histogram;
	import hphh_pkg::*;

	localparam int CAPACITY     = 64;
	localparam int RANDOM_ITEMS = 92;
	localparam int DRAIN_CYCLES = 80;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                action;
	logic [HASH_W-1:0]   hash_value;
	logic [BIN_W-1:0]    bin_select;
	logic                cfg_we;
	logic [BIN_W-1:0]    cfg_data;
	logic                strobe;
	logic [1:0]          kind;
	logic [IDX_W-1:0]    older_index;
	logic [IDX_W-1:0]    newer_index;
	logic [BIN_W-1:0]    distance;
	logic [TALLY_W-1:0]  tally;
	logic                last;
	int                  fail_count;
	int                  pending;

	logic [HASH_W-1:0]   sent_hashes [$];
	int                  inserts_sent = 0;

	hash_pair_hamming_histogram #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.hash_value(hash_value),
		.bin_select(bin_select),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.kind(kind),
		.older_index(older_index),
		.newer_index(newer_index),
		.distance(distance),
		.tally(tally),
		.last(last)
	);

	hash_pair_hamming_histogram_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.hash_value(hash_value),
		.bin_select(bin_select),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.kind(kind),
		.older_index(older_index),
		.newer_index(newer_index),
		.distance(distance),
		.tally(tally),
		.last(last),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
	end

	always #2 clk = ~clk;

	function automatic logic [HASH_W-1:0] random_hash();
		return {$urandom, $urandom};
	endfunction

	// Called at a falling edge; busy is stable there and holds the value that
	// the next rising edge samples. Returns at the falling edge after acceptance.
	task automatic send_request(input hphh_action_t act, input logic [HASH_W-1:0] hv,
			input logic [BIN_W-1:0] bin);
		start <= 1'b1;
		action <= act;
		hash_value <= hv;
		bin_select <= bin;
		while (busy) @(negedge clk);
		@(negedge clk);
		if (act == ACT_INSERT) begin
			inserts_sent++;
			sent_hashes = {sent_hashes, hv};
		end
	endtask

	task automatic send_insert(input logic [HASH_W-1:0] hv);
		send_request(ACT_INSERT, hv, BIN_W'($urandom_range(0, 127)));
	endtask

	task automatic send_read(input logic [BIN_W-1:0] bin);
		send_request(ACT_READ, random_hash(), bin);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy) @(negedge clk);
	endtask

	task automatic write_limit(input logic [BIN_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly near copies of earlier hashes so that close pairs occur often.
	task automatic send_random_request();
		int pick;
		int flips;
		logic [HASH_W-1:0] hv;
		pick = $urandom_range(0, 99);
		if (pick < 55 && sent_hashes.size() > 0) begin
			hv = sent_hashes[$urandom_range(0, sent_hashes.size() - 1)];
			flips = $urandom_range(0, 10);
			repeat (flips) hv[$urandom_range(0, HASH_W - 1)] ^= 1'b1;
			send_insert(hv);
		end else if (pick < 70) begin
			send_insert(random_hash());
		end else if ($urandom_range(0, 3) == 0) begin
			send_read(BIN_W'($urandom_range(0, 127)));
		end else begin
			send_read(BIN_W'($urandom_range(0, 64)));
		end
	endtask

	function automatic logic [BIN_W-1:0] pick_limit();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return BIN_W'(64);
			2: return BIN_W'(127);
			3: return BIN_W'($urandom_range(1, 16));
			default: return BIN_W'($urandom_range(0, 127));
		endcase
	endfunction

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int random_sent;
		int next_cfg_at;
		int burst_len;
		int gap;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_INSERT;
		hash_value = '0;
		bin_select = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty histogram, including bins beyond the last one.
		write_limit('0);
		send_read('0);
		send_read(BIN_W'(64));
		send_read(BIN_W'(65));
		send_read(BIN_W'(127));
		send_insert('0);
		send_insert('1);
		send_insert('0);
		send_read('0);
		send_read(BIN_W'(64));

		write_limit(BIN_W'(64));
		send_insert(64'h0000_0000_FFFF_FFFF);
		send_insert(64'h0000_0000_0000_0001);
		send_read(BIN_W'(32));

		// A limit above the largest distance reports every pair.
		write_limit(BIN_W'(127));
		send_insert(64'hA5A5_A5A5_A5A5_A5A5);
		send_insert(64'h5A5A_5A5A_5A5A_5A5A);
		send_read(BIN_W'(1));

		write_limit(BIN_W'($urandom_range(1, 16)));
		random_sent = 0;
		next_cfg_at = 22;
		while (random_sent < RANDOM_ITEMS) begin
			if (random_sent >= next_cfg_at) begin
				write_limit(pick_limit());
				next_cfg_at += 22;
			end
			burst_len = $urandom_range(1, 8);
			repeat (burst_len) begin
				send_random_request();
				random_sent++;
			end
			case ($urandom_range(0, 2))
				0: gap = 0;
				1: gap = $urandom_range(1, 6);
				default: gap = $urandom_range(1, 80);
			endcase
			// With no gap the request line stays high into the next burst.
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end

		// Make sure the store fills up and refuses further inserts.
		while (inserts_sent < CAPACITY + 3) begin
			send_insert(random_hash());
		end
		send_read(BIN_W'($urandom_range(0, 64)));

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
